>>> hdl/dcc_pkg.sv
// ----------------------------------------------------------------------------
// dcc_pkg
// Shared widths, register indexes and reset values of the click classifier.
// ----------------------------------------------------------------------------
package dcc_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int CFG_WIDTH   = 16;
	localparam int IDX_WIDTH   = 8;
	localparam int CMP_WIDTH   = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [CFG_WIDTH-1:0]   cfg_t;
	typedef logic [IDX_WIDTH-1:0]   idx_t;
	typedef logic [CMP_WIDTH-1:0]   cmp_t;

	localparam idx_t REG_DEBOUNCE_TICKS     = idx_t'(0);
	localparam idx_t REG_DOUBLE_CLICK_TICKS = idx_t'(1);

	localparam cfg_t DEBOUNCE_TICKS_RST     = cfg_t'(35);
	localparam cfg_t DOUBLE_CLICK_TICKS_RST = cfg_t'(320);

	localparam count_t COUNT_MAX = '1;

	function automatic count_t sat_inc(input count_t v);
		return (v == COUNT_MAX) ? COUNT_MAX : v + count_t'(1);
	endfunction

endpackage

>>> hdl/dcc_if.sv
// ----------------------------------------------------------------------------
// dcc_if
// Valid/ready channels for button samples and click results.
// ----------------------------------------------------------------------------
interface dcc_sample_if;
	logic valid;
	logic ready;
	logic raw_level;

	modport source (output valid, output raw_level, input ready);
	modport sink (input valid, input raw_level, output ready);
endinterface

interface dcc_result_if;
	logic valid;
	logic ready;
	logic single_click;
	logic double_click;
	logic stable_pressed;

	modport source (output valid, output single_click, output double_click,
		output stable_pressed, input ready);
	modport sink (input valid, input single_click, input double_click,
		input stable_pressed, output ready);
endinterface

>>> hdl/debounced_click_classifier.sv
// ----------------------------------------------------------------------------
// debounced_click_classifier
// Debounces an active-low button and classifies releases as single or
// double clicks, one sample per tick.
// ----------------------------------------------------------------------------
// One result comes back for every sample: the sample is registered, then
// the debounce, counter and click logic runs in a single pass into the
// result register. With the result side ready the block sustains one sample
// per cycle; a stalled result register holds the sample register, which
// then holds off the sample side. Write configuration only while no sample
// is in flight; index 0 sets the debounce time, index 1 the double-click
// window.
module debounced_click_classifier
	import dcc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  idx_t             cfg_index,
	input  cfg_t             cfg_data,
	dcc_sample_if.sink       sample,
	dcc_result_if.source     result
);

	// configuration
	cfg_t debounce_ticks_q;
	cfg_t double_click_ticks_q;

	// click state
	logic   previous_sample_q;
	logic   debounced_level_q;
	count_t ticks_since_change_q;
	logic   click_waiting_q;
	count_t ticks_since_release_q;

	// sample register
	logic valid_s1;
	logic raw_s1;

	// result register
	logic valid_s2;
	logic single_s2;
	logic double_s2;
	logic pressed_s2;

	logic advance;

	// next-state logic
	logic   change;
	count_t tsc_n;
	count_t tsr_inc;
	logic   take_level;
	logic   debounced_n;
	logic   released;
	logic   dbl_c;
	logic   waiting_a;
	count_t tsr_n;
	logic   single_c;
	logic   waiting_n;

	assign advance      = valid_s1 && (!valid_s2 || result.ready);
	assign sample.ready = !valid_s1 || advance;

	assign result.valid          = valid_s2;
	assign result.single_click   = single_s2;
	assign result.double_click   = double_s2;
	assign result.stable_pressed = pressed_s2;

	always_comb begin
		change      = raw_s1 != previous_sample_q;
		tsc_n       = change ? '0 : sat_inc(ticks_since_change_q);
		tsr_inc     = sat_inc(ticks_since_release_q);
		take_level  = (cmp_t'(tsc_n) >= cmp_t'(debounce_ticks_q))
			&& (raw_s1 != debounced_level_q);
		debounced_n = take_level ? raw_s1 : debounced_level_q;
		released    = take_level && raw_s1;
		dbl_c       = released && click_waiting_q
			&& (cmp_t'(tsr_inc) <= cmp_t'(double_click_ticks_q));
		waiting_a   = released ? !dbl_c : click_waiting_q;
		tsr_n       = released ? '0 : tsr_inc;
		single_c    = waiting_a && debounced_n
			&& (cmp_t'(tsr_n) > cmp_t'(double_click_ticks_q));
		waiting_n   = waiting_a && !single_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ticks_q     <= DEBOUNCE_TICKS_RST;
			double_click_ticks_q <= DOUBLE_CLICK_TICKS_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_DEBOUNCE_TICKS) begin
				debounce_ticks_q <= cfg_data;
			end
			if (cfg_index == REG_DOUBLE_CLICK_TICKS) begin
				double_click_ticks_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			previous_sample_q     <= 1'b1;
			debounced_level_q     <= 1'b1;
			ticks_since_change_q  <= '0;
			click_waiting_q       <= 1'b0;
			ticks_since_release_q <= '0;
		end else if (advance) begin
			previous_sample_q     <= raw_s1;
			debounced_level_q     <= debounced_n;
			ticks_since_change_q  <= tsc_n;
			click_waiting_q       <= waiting_n;
			ticks_since_release_q <= tsr_n;
		end
	end

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (sample.ready) begin
				valid_s1 <= sample.valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			raw_s1 <= sample.raw_level;
		end
		if (advance) begin
			single_s2  <= single_c;
			double_s2  <= dbl_c;
			pressed_s2 <= !debounced_n;
		end
	end

	a_single_excl_double: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(single_s2 && double_s2))
		else $error("single and double click reported together");

	a_click_while_released: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (single_s2 || double_s2) |-> !pressed_s2)
		else $error("click reported while button held");

	a_double_clears_wait: assert property (@(posedge clk) disable iff (!arst_n)
		advance && dbl_c |=> !click_waiting_q && ticks_since_release_q == '0)
		else $error("double click left a click waiting");

	a_stall_holds_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !result.ready |=> valid_s2 && $stable(single_s2)
			&& $stable(double_s2) && $stable(pressed_s2))
		else $error("stalled result changed");

endmodule

>>> dv/debounced_click_classifier_tb.sv
// ----------------------------------------------------------------------------
// debounced_click_classifier_tb
// Drives tick-by-tick button levels through the sample channel and predicts
// each result in step with the DUT. Every result transfer is compared field
// by field with the oldest prediction. Phases cover the reset configuration,
// short directed clicks, ignored indexes, zero debounce time, full-scale
// debounce and window settings, and random press/release traffic under
// several configurations, with and without idle cycles on both channels.
// ----------------------------------------------------------------------------
module debounced_click_classifier_tb;
	import dcc_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic single_click;
		logic double_click;
		logic stable_pressed;
	} click_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	idx_t cfg_index;
	cfg_t cfg_data;

	dcc_sample_if sample_ch();
	dcc_result_if result_ch();

	debounced_click_classifier DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample_ch),
		.result    (result_ch)
	);

	// Predicted button state and configuration
	cfg_t   debounce_cfg;
	cfg_t   window_cfg;
	logic   last_raw;
	logic   settled_level;
	count_t change_age;
	logic   click_pending;
	count_t release_age;

	click_result_t expected_clicks[$];
	int            errors;
	int            stall_cycles;
	bit            idle_enable;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.raw_level = 1'b1;
		result_ch.ready = 1'b0;
		idle_enable = 1'b1;
		errors = 0;
		stall_cycles = 0;
	end

	always #2 clk = ~clk;

	function automatic count_t bump(input count_t v);
		return (v == COUNT_MAX) ? v : v + count_t'(1);
	endfunction

	function automatic click_result_t classify_tick(input logic raw);
		click_result_t r;
		logic released;
		r = '0;
		released = 1'b0;
		if (raw != last_raw) begin
			last_raw = raw;
			change_age = '0;
		end else begin
			change_age = bump(change_age);
		end
		release_age = bump(release_age);
		if (change_age >= debounce_cfg && raw != settled_level) begin
			settled_level = raw;
			released = raw;
		end
		if (released) begin
			if (click_pending && release_age <= window_cfg) begin
				r.double_click = 1'b1;
				click_pending = 1'b0;
			end else begin
				click_pending = 1'b1;
			end
			release_age = '0;
		end
		if (click_pending && settled_level && release_age > window_cfg) begin
			r.single_click = 1'b1;
			click_pending = 1'b0;
		end
		r.stable_pressed = ~settled_level;
		return r;
	endfunction

	// Predict on each sample transfer, check each result transfer
	always @(posedge clk) begin
		click_result_t got;
		click_result_t want;
		if (!arst_n) begin
			debounce_cfg = DEBOUNCE_TICKS_RST;
			window_cfg = DOUBLE_CLICK_TICKS_RST;
			last_raw = 1'b1;
			settled_level = 1'b1;
			change_age = '0;
			click_pending = 1'b0;
			release_age = '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_DEBOUNCE_TICKS: debounce_cfg = cfg_data;
					REG_DOUBLE_CLICK_TICKS: window_cfg = cfg_data;
					default: ;
				endcase
			end
			if (sample_ch.valid && sample_ch.ready)
				expected_clicks.push_back(classify_tick(sample_ch.raw_level));
			if (result_ch.valid && result_ch.ready) begin
				got.single_click = result_ch.single_click;
				got.double_click = result_ch.double_click;
				got.stable_pressed = result_ch.stable_pressed;
				if (expected_clicks.size() == 0) begin
					errors++;
					$display("%0t: unexpected result transfer %b/%b/%b", $time,
						got.single_click, got.double_click, got.stable_pressed);
				end else begin
					want = expected_clicks.pop_front();
					if (got.single_click !== want.single_click) begin
						errors++;
						$display("%0t: single_click expected %b actual %b", $time,
							want.single_click, got.single_click);
					end
					if (got.double_click !== want.double_click) begin
						errors++;
						$display("%0t: double_click expected %b actual %b", $time,
							want.double_click, got.double_click);
					end
					if (got.stable_pressed !== want.stable_pressed) begin
						errors++;
						$display("%0t: stable_pressed expected %b actual %b", $time,
							want.stable_pressed, got.stable_pressed);
					end
				end
			end
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
				|| cfg_we)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("debounced_click_classifier_tb: FAIL");
				$finish;
			end
		end
	end

	always @(negedge clk)
		result_ch.ready <= !idle_enable || ($urandom_range(0, 99) >= 16);

	// Called at a falling edge; returns at the falling edge after the transfer
	task automatic send_tick(input logic lvl);
		while (idle_enable && $urandom_range(0, 99) < 16) begin
			sample_ch.valid <= 1'b0;
			@(negedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.raw_level <= lvl;
		do @(posedge clk); while (!sample_ch.ready);
		@(negedge clk);
	endtask

	task automatic send_run(input logic lvl, input int n);
		repeat (n) send_tick(lvl);
	endtask

	// Hold the sample side and wait until every prediction has been matched
	task automatic drain;
		sample_ch.valid <= 1'b0;
		while (expected_clicks.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(input idx_t idx, input cfg_t value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic configure(input cfg_t deb, input cfg_t win);
		drain;
		write_reg(REG_DEBOUNCE_TICKS, deb);
		write_reg(REG_DOUBLE_CLICK_TICKS, win);
	endtask

	// Alternate press and release runs, mostly long enough to settle,
	// with some glitches shorter than the debounce time
	task automatic run_random(input int n_items);
		int   sent;
		int   len;
		int   deb;
		int   span;
		logic lvl;
		sent = 0;
		lvl = 1'b0;
		while (sent < n_items) begin
			deb = int'(debounce_cfg);
			span = (int'(window_cfg) + 4 > 400) ? 400 : int'(window_cfg) + 4;
			if ($urandom_range(0, 99) < 80)
				len = lvl ? deb + 1 + $urandom_range(0, span) : deb + 1 + $urandom_range(0, 3);
			else
				len = $urandom_range(1, (deb > 0) ? deb : 1);
			if (len > n_items - sent)
				len = n_items - sent;
			send_run(lvl, len);
			sent += len;
			lvl = ~lvl;
		end
	endtask

	task automatic test_reset_defaults;
		run_random(250);
	endtask

	task automatic test_directed_clicks;
		configure(cfg_t'(1), cfg_t'(6));
		send_run(1'b0, 2);
		send_run(1'b1, 2);
		send_run(1'b0, 2);
		send_run(1'b1, 2);
		send_run(1'b0, 2);
		send_run(1'b1, 9);
		// glitch shorter than the debounce time
		send_run(1'b0, 1);
		send_run(1'b1, 2);
	endtask

	task automatic test_ignored_index;
		drain;
		write_reg(idx_t'(8'hFF), cfg_t'(16'h0000));
		write_reg(idx_t'(8'hFE), cfg_t'(16'hFFFF));
		send_run(1'b0, 2);
		send_run(1'b1, 9);
	endtask

	task automatic test_zero_debounce;
		configure(cfg_t'(0), cfg_t'(0));
		send_run(1'b0, 1);
		send_run(1'b1, 3);
		configure(cfg_t'(0), cfg_t'(2));
		send_run(1'b0, 1);
		send_run(1'b1, 1);
		send_run(1'b0, 1);
		send_run(1'b1, 4);
	endtask

	// Full-scale debounce holds the level; full-scale window keeps a click waiting
	task automatic test_full_scale_settings;
		configure(cfg_t'(16'hFFFF), cfg_t'(16'hFFFF));
		send_run(1'b0, 100);
		send_run(1'b1, 4);
		configure(cfg_t'(1), cfg_t'(16'hFFFF));
		send_run(1'b0, 2);
		send_run(1'b1, 150);
		// still pending: the window has not closed, so this is a double
		send_run(1'b0, 2);
		send_run(1'b1, 4);
	endtask

	task automatic test_random_traffic;
		configure(cfg_t'(0), cfg_t'(0));
		run_random(80);
		configure(cfg_t'(1), cfg_t'(1));
		run_random(80);
		configure(cfg_t'(3), cfg_t'(10));
		run_random(80);
		configure(cfg_t'(5), cfg_t'(40));
		run_random(80);
		configure(cfg_t'($urandom_range(0, 8)), cfg_t'($urandom_range(0, 60)));
		run_random(80);
	endtask

	task automatic test_no_idle_burst;
		configure(cfg_t'(2), cfg_t'(12));
		idle_enable = 1'b0;
		run_random(150);
		idle_enable = 1'b1;
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_defaults();
		test_directed_clicks();
		test_ignored_index();
		test_zero_debounce();
		test_full_scale_settings();
		test_random_traffic();
		test_no_idle_burst();
		drain;
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("debounced_click_classifier_tb: PASS");
		else
			$display("debounced_click_classifier_tb: FAIL");
		$finish;
	end

endmodule
